>>> hw/rtl/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types and constants of the cluster chain engine: action codes,
// status codes and the link values of the allocation table.
// ----------------------------------------------------------------------------
package fcce_pkg;

	typedef logic [2:0] status_t;
	typedef logic [2:0] action_t;

	localparam int FCCE_ENTRIES = 4096;

	localparam action_t ACT_WRITE = 3'd0;
	localparam action_t ACT_NEXT  = 3'd1;
	localparam action_t ACT_LAST  = 3'd2;
	localparam action_t ACT_COUNT = 3'd3;
	localparam action_t ACT_ALLOC = 3'd4;

	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_END    = 3'd1;
	localparam status_t ST_BAD    = 3'd2;
	localparam status_t ST_NOFREE = 3'd3;
	localparam status_t ST_RANGE  = 3'd4;
	localparam status_t ST_LONG   = 3'd5;

	localparam logic [27:0] LINK_EOC     = 28'hFFFFFFF;
	localparam logic [27:0] LINK_END_MIN = 28'hFFFFFF8;
	localparam logic [27:0] LINK_BAD     = 28'hFFFFFF7;
	localparam logic [12:0] COUNT_SAT    = 13'h1FFF;

endpackage

>>> hw/rtl/fcce_if.sv
// ----------------------------------------------------------------------------
// fcce_req_if / fcce_rsp_if
// Valid/ready channels carrying request items into the engine and result
// items out of it.
// ----------------------------------------------------------------------------
interface fcce_req_if import fcce_pkg::*; ();
	logic        valid;
	logic        ready;
	action_t     action;
	logic [27:0] cluster;
	logic [31:0] entry_value;

	modport source (output valid, output action, output cluster, output entry_value,
		input ready);
	modport sink (input valid, input action, input cluster, input entry_value,
		output ready);
endinterface

interface fcce_rsp_if import fcce_pkg::*; ();
	logic        valid;
	logic        ready;
	status_t     status;
	logic [27:0] cluster_out;
	logic [12:0] chain_count;
	logic [11:0] next_free;
	logic [12:0] free_count;

	modport source (output valid, output status, output cluster_out, output chain_count,
		output next_free, output free_count, input ready);
	modport sink (input valid, input status, input cluster_out, input chain_count,
		input next_free, input free_count, output ready);
endinterface

>>> hw/rtl/fcce_table.sv
// ----------------------------------------------------------------------------
// fcce_table
// Allocation table memory: one write port and one read port, read data
// registered. Contents are not reset; the engine clears it after reset.
// ----------------------------------------------------------------------------
module fcce_table import fcce_pkg::*; #(
	parameter int ENTRIES = FCCE_ENTRIES,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [ENTRIES];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fat_cluster_chain_engine.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine
// FAT32 allocation table engine: stores table words, follows links, walks
// and counts chains, and allocates a free cluster onto the end of a chain.
//
//   channel  role     handshake     payload
//   req      sink     valid/ready   action, cluster, entry_value
//   rsp      source   valid/ready   status, cluster_out, chain_count,
//                                   next_free, free_count
//   cfg      sink     cfg_wr_en     cfg_wr_data (free count preset)
//
// One item at a time. write_entry and unknown actions go from dispatch straight to
// the result and next adds one link check; last and count walk the chain step by
// step, since every chain step is a dependent read of the single table read port.
// Allocate adds a free scan at one entry per cycle, the chain walk, and a
// second scan from the new cluster onward for the free hint.
// After reset the table is cleared one entry per cycle; req.ready stays low
// meanwhile. A result waiting on rsp does not block the next item from being
// accepted, only from being reported.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine import fcce_pkg::*; #(
	parameter int ENTRIES = FCCE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	fcce_req_if.sink    req,
	fcce_rsp_if.source  rsp,
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = AW + 1;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_NEXTC = 4'd3;
	localparam logic [3:0] S_WISS  = 4'd4;
	localparam logic [3:0] S_WCHK  = 4'd5;
	localparam logic [3:0] S_WEND  = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_MARK  = 4'd8;
	localparam logic [3:0] S_UNDO  = 4'd9;
	localparam logic [3:0] S_LINK  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          rsp_valid_q;
	logic [12:0]   freecnt_q;
	logic [AW-1:0] hint_q;

	action_t       act_q;
	logic [27:0]   cl_q;
	logic [31:0]   val_q;
	status_t       st_q;
	logic [27:0]   cout_q;
	logic [12:0]   ccount_q;
	logic [27:0]   cur_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] f_q;
	logic [CW-1:0] scan_q;
	logic          pend_v_q;
	logic [AW-1:0] pend_a_q;
	logic          hint_mode_q;

	status_t       rsp_status_q;
	logic [27:0]   rsp_cout_q;
	logic [12:0]   rsp_ccount_q;
	logic [11:0]   rsp_nfree_q;
	logic [12:0]   rsp_fcount_q;

	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	logic [31:0]   tbl_wdata;
	logic          tbl_re;
	logic [AW-1:0] tbl_raddr;
	logic [31:0]   tbl_rdata;

	logic [27:0]   link_v;
	logic          link_end;
	logic          link_bad;
	logic          cl_in_range;
	logic          cur_in_range;
	logic          scan_in_range;
	logic [31:0]   n_ext;
	logic [31:0]   hint_ext;

	fcce_table #(.ENTRIES(ENTRIES)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// The one decode and compare unit shared by next, walk and scan steps.
	assign link_v        = tbl_rdata[27:0];
	assign link_end      = (link_v >= LINK_END_MIN);
	assign link_bad      = (link_v == LINK_BAD);
	assign cl_in_range   = (cl_q < 28'(ENTRIES));
	assign cur_in_range  = (cur_q < 28'(ENTRIES));
	assign scan_in_range = (scan_q < CW'(ENTRIES));
	assign n_ext         = 32'(n_q);
	assign hint_ext      = 32'(hint_q);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		tbl_re    = 1'b0;
		tbl_raddr = '0;
		case (state_q)
			S_CLR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_q;
			end
			S_DISP: begin
				if (act_q == ACT_WRITE && cl_in_range) begin
					tbl_we    = 1'b1;
					tbl_waddr = cl_q[AW-1:0];
					tbl_wdata = val_q;
				end
				if (act_q == ACT_NEXT && cl_in_range) begin
					tbl_re    = 1'b1;
					tbl_raddr = cl_q[AW-1:0];
				end
			end
			S_WISS: begin
				tbl_re    = cur_in_range;
				tbl_raddr = cur_q[AW-1:0];
			end
			S_SCAN: begin
				tbl_re    = scan_in_range;
				tbl_raddr = scan_q[AW-1:0];
			end
			S_MARK: begin
				tbl_we    = 1'b1;
				tbl_waddr = f_q;
				tbl_wdata = {4'h0, LINK_EOC};
			end
			S_UNDO: begin
				tbl_we    = 1'b1;
				tbl_waddr = f_q;
			end
			S_LINK: begin
				tbl_we    = 1'b1;
				tbl_waddr = last_q;
				tbl_wdata = 32'(f_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			freecnt_q   <= '0;
			hint_q      <= '0;
			st_q        <= ST_OK;
			cout_q      <= '0;
			ccount_q    <= '0;
			cur_q       <= '0;
			n_q         <= '0;
			last_q      <= '0;
			f_q         <= '0;
			scan_q      <= '0;
			pend_v_q    <= 1'b0;
			pend_a_q    <= '0;
			hint_mode_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				freecnt_q <= cfg_wr_data;
			end else if (state_q == S_LINK && freecnt_q != '0) begin
				freecnt_q <= freecnt_q - 13'd1;
			end

			if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						st_q     <= ST_OK;
						cout_q   <= '0;
						ccount_q <= '0;
						state_q  <= S_DISP;
					end
				end
				S_DISP: begin
					cur_q       <= cl_q;
					n_q         <= '0;
					scan_q      <= CW'(2);
					pend_v_q    <= 1'b0;
					hint_mode_q <= 1'b0;
					case (act_q)
						ACT_WRITE: begin
							if (!cl_in_range) begin
								st_q <= ST_RANGE;
							end
							state_q <= S_FIN;
						end
						ACT_NEXT: begin
							if (cl_in_range) begin
								state_q <= S_NEXTC;
							end else begin
								st_q    <= ST_RANGE;
								state_q <= S_FIN;
							end
						end
						ACT_LAST, ACT_COUNT: begin
							state_q <= S_WISS;
						end
						ACT_ALLOC: begin
							state_q <= S_SCAN;
						end
						default: begin
							st_q    <= ST_RANGE;
							state_q <= S_FIN;
						end
					endcase
				end
				S_NEXTC: begin
					if (link_end) begin
						st_q <= ST_END;
					end else if (link_bad) begin
						st_q <= ST_BAD;
					end else begin
						cout_q <= link_v;
					end
					state_q <= S_FIN;
				end
				S_WISS: begin
					if (!cur_in_range) begin
						st_q    <= ST_RANGE;
						state_q <= S_WEND;
					end else begin
						n_q     <= n_q + CW'(1);
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (link_end) begin
						st_q    <= ST_OK;
						last_q  <= cur_q[AW-1:0];
						state_q <= S_WEND;
					end else if (link_bad) begin
						st_q    <= ST_BAD;
						state_q <= S_WEND;
					end else if (n_q >= CW'(ENTRIES)) begin
						st_q    <= ST_LONG;
						state_q <= S_WEND;
					end else begin
						cur_q   <= link_v;
						state_q <= S_WISS;
					end
				end
				S_WEND: begin
					case (act_q)
						ACT_LAST: begin
							if (st_q == ST_OK) begin
								cout_q <= 28'(last_q);
							end
							state_q <= S_FIN;
						end
						ACT_COUNT: begin
							ccount_q <= (n_ext > 32'(COUNT_SAT)) ? COUNT_SAT : n_ext[12:0];
							state_q  <= S_FIN;
						end
						ACT_ALLOC: begin
							state_q <= (st_q == ST_OK) ? S_LINK : S_UNDO;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_SCAN: begin
					// Reads are issued one entry per cycle; the data of the
					// previous address is checked against zero here.
					if (pend_v_q && tbl_rdata == 32'd0) begin
						if (hint_mode_q) begin
							hint_q  <= pend_a_q;
							state_q <= S_FIN;
						end else begin
							f_q     <= pend_a_q;
							state_q <= S_MARK;
						end
					end else if (!scan_in_range) begin
						if (hint_mode_q) begin
							hint_q <= '0;
						end else begin
							st_q <= ST_NOFREE;
						end
						state_q <= S_FIN;
					end else begin
						pend_v_q <= 1'b1;
						pend_a_q <= scan_q[AW-1:0];
						scan_q   <= scan_q + CW'(1);
					end
				end
				S_MARK: begin
					state_q <= S_WISS;
				end
				S_UNDO: begin
					state_q <= S_FIN;
				end
				S_LINK: begin
					// Entries from cluster 2 up to the new cluster are all in use, so the
					// hint scan resumes just past it.
					cout_q      <= 28'(f_q);
					scan_q      <= CW'(f_q) + CW'(1);
					pend_v_q    <= 1'b0;
					hint_mode_q <= 1'b1;
					state_q     <= S_SCAN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture and result register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			act_q <= req.action;
			cl_q  <= req.cluster;
			val_q <= req.entry_value;
		end
		if (state_q == S_FIN && (!rsp_valid_q || rsp.ready)) begin
			rsp_status_q <= st_q;
			rsp_cout_q   <= cout_q;
			rsp_ccount_q <= ccount_q;
			rsp_nfree_q  <= hint_ext[11:0];
			rsp_fcount_q <= freecnt_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.cluster_out = rsp_cout_q;
	assign rsp.chain_count = rsp_ccount_q;
	assign rsp.next_free   = rsp_nfree_q;
	assign rsp.free_count  = rsp_fcount_q;

	// The table is never written while the engine waits for an item.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !tbl_we)
		else $error("table written while idle");

	// The free counter moves only on a preset or a successful allocation.
	a_freecnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!cfg_wr_en && state_q != S_LINK) |=> $stable(freecnt_q))
		else $error("free counter changed unexpectedly");

	// A walk never reads more than ENTRIES clusters.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCHK || state_q == S_WISS) |-> (n_q <= CW'(ENTRIES)))
		else $error("chain walk exceeded table size");

	// A finished result is never dropped on top of an unread one.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready && state_q == S_FIN) |=> (state_q == S_FIN))
		else $error("result overwritten before it was taken");

endmodule
